// File: design/uotfp_pkg.sv
// Package for the datagram-over-stream frame parser: result kinds, family codes,
// parse phase encoding and the result record shared by the parser and the output stage.
// No dependencies.
package uotfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned KIND_W = 3;

    // Result kinds carried on m_result_kind.
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PROTO_ERR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SIZE_ERR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STREAM_END = 3'd4;

    // Address family byte values.
    localparam logic [BYTE_W-1:0] FAM_IPV4   = 8'h00;
    localparam logic [BYTE_W-1:0] FAM_IPV6   = 8'h01;
    localparam logic [BYTE_W-1:0] FAM_DOMAIN = 8'h02;

    // Address lengths in bytes.
    localparam logic [WORD_W:0] ADDR_BYTES_V4 = 17'd4;
    localparam logic [WORD_W:0] ADDR_BYTES_V6 = 17'd16;
    localparam logic [WORD_W:0] FIELD_BYTES   = 17'd2;

    typedef enum logic [5:0] {
        PH_FAMILY  = 6'b000001,
        PH_DOMAIN  = 6'b000010,
        PH_ADDR    = 6'b000100,
        PH_PORT    = 6'b001000,
        PH_LEN     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last_of_datagram;
        logic                source_is_ipv6;
        logic [ADDR_W-1:0]   source_addr_high;
        logic [ADDR_W-1:0]   source_addr_low;
        logic [WORD_W-1:0]   source_port;
        logic [WORD_W-1:0]   datagram_length;
    } result_t;

endpackage

// File: design/uotfp_parser.sv
// Frame parser: header state registers, capacity register and the single-pass
// next-state and result logic for one stream byte. Depends on uotfp_pkg.
module uotfp_parser
    import uotfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    output result_t           res
);

    phase_t             phase_reg, phase_next;
    logic [WORD_W-1:0]  count_reg, count_next;
    logic               ipv6_reg, ipv6_next;
    logic [ADDR_W-1:0]  addr_hi_reg, addr_hi_next;
    logic [ADDR_W-1:0]  addr_lo_reg, addr_lo_next;
    logic [WORD_W-1:0]  port_reg, port_next;
    logic [WORD_W-1:0]  length_reg, length_next;
    logic               oversize_reg, oversize_next;
    logic [WORD_W-1:0]  capacity_reg;
    logic [WORD_W:0]    count_inc;
    logic               emit;
    logic               emit_header;
    logic [KIND_W-1:0]  emit_kind;
    logic               emit_last;

    assign count_inc = {1'b0, count_reg} + 17'd1;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        ipv6_next     = ipv6_reg;
        addr_hi_next  = addr_hi_reg;
        addr_lo_next  = addr_lo_reg;
        port_next     = port_reg;
        length_next   = length_reg;
        oversize_next = oversize_reg;
        emit          = 1'b0;
        emit_header   = 1'b0;
        emit_kind     = KIND_PAYLOAD;
        emit_last     = 1'b0;

        if (in_accept) begin
            if (in_end) begin
                phase_next    = PH_FAMILY;
                count_next    = '0;
                oversize_next = 1'b0;
                emit          = 1'b1;
                emit_kind     = KIND_STREAM_END;
            end else begin
                unique case (phase_reg)
                    PH_DOMAIN: begin
                        phase_next    = PH_FAMILY;
                        count_next    = '0;
                        oversize_next = 1'b0;
                        emit          = 1'b1;
                        emit_kind     = KIND_PROTO_ERR;
                    end
                    PH_ADDR: begin
                        if (ipv6_reg) begin
                            addr_hi_next = {addr_hi_reg[ADDR_W-BYTE_W-1:0],
                                            addr_lo_reg[ADDR_W-1:ADDR_W-BYTE_W]};
                            addr_lo_next = {addr_lo_reg[ADDR_W-BYTE_W-1:0], in_byte};
                        end else begin
                            addr_lo_next = {32'd0, addr_lo_reg[23:0], in_byte};
                        end
                        count_next = count_inc[WORD_W-1:0];
                        if (count_inc >= (ipv6_reg ? ADDR_BYTES_V6 : ADDR_BYTES_V4)) begin
                            count_next = '0;
                            phase_next = PH_PORT;
                        end
                    end
                    PH_PORT: begin
                        port_next  = {port_reg[BYTE_W-1:0], in_byte};
                        count_next = count_inc[WORD_W-1:0];
                        if (count_inc >= FIELD_BYTES) begin
                            count_next = '0;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        length_next = {length_reg[BYTE_W-1:0], in_byte};
                        count_next  = count_inc[WORD_W-1:0];
                        if (count_inc >= FIELD_BYTES) begin
                            count_next = '0;
                            if (length_next == '0) begin
                                phase_next    = PH_FAMILY;
                                oversize_next = 1'b0;
                                emit          = 1'b1;
                                emit_header   = 1'b1;
                                emit_kind     = KIND_EMPTY;
                            end else begin
                                oversize_next = (length_next > capacity_reg);
                                phase_next    = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        count_next = count_inc[WORD_W-1:0];
                        emit_last  = (count_inc >= {1'b0, length_reg});
                        if (emit_last) begin
                            phase_next    = PH_FAMILY;
                            count_next    = '0;
                            oversize_next = 1'b0;
                        end
                        if (oversize_reg) begin
                            emit      = emit_last;
                            emit_kind = KIND_SIZE_ERR;
                            emit_last = 1'b0;
                        end else begin
                            emit        = 1'b1;
                            emit_header = 1'b1;
                            emit_kind   = KIND_PAYLOAD;
                        end
                    end
                    default: begin
                        // Waiting for a family byte; unused codes land here too.
                        phase_next    = PH_FAMILY;
                        count_next    = '0;
                        oversize_next = 1'b0;
                        if (in_byte == FAM_IPV4 || in_byte == FAM_IPV6) begin
                            ipv6_next    = (in_byte == FAM_IPV6);
                            addr_hi_next = '0;
                            addr_lo_next = '0;
                            port_next    = '0;
                            length_next  = '0;
                            phase_next   = PH_ADDR;
                        end else if (in_byte == FAM_DOMAIN) begin
                            phase_next = PH_DOMAIN;
                        end else begin
                            emit      = 1'b1;
                            emit_kind = KIND_PROTO_ERR;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        res                  = '0;
        res.valid            = emit;
        res.kind             = emit_kind;
        if (emit_header) begin
            res.payload_byte     = (emit_kind == KIND_PAYLOAD) ? in_byte : '0;
            res.last_of_datagram = emit_last;
            res.source_is_ipv6   = ipv6_next;
            res.source_addr_high = addr_hi_next;
            res.source_addr_low  = addr_lo_next;
            res.source_port      = port_next;
            res.datagram_length  = length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FAMILY;
            count_reg    <= '0;
            ipv6_reg     <= 1'b0;
            addr_hi_reg  <= '0;
            addr_lo_reg  <= '0;
            port_reg     <= '0;
            length_reg   <= '0;
            oversize_reg <= 1'b0;
            capacity_reg <= 16'hffff;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            ipv6_reg     <= ipv6_next;
            addr_hi_reg  <= addr_hi_next;
            addr_lo_reg  <= addr_lo_next;
            port_reg     <= port_next;
            length_reg   <= length_next;
            oversize_reg <= oversize_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // The address counter never runs past the longest address.
    a_addr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ADDR |-> count_reg < 16'd16)
        else $error("address byte counter out of range");

    // A payload phase is only entered with a non-zero length.
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> length_reg != '0)
        else $error("payload phase with zero length");

    // The final payload byte returns the parser to the family byte.
    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == KIND_PAYLOAD && res.last_of_datagram
        |=> phase_reg == PH_FAMILY && count_reg == '0)
        else $error("parser did not return to family phase after last byte");

    // Error and end results carry no header.
    a_err_no_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind != KIND_PAYLOAD && res.kind != KIND_EMPTY
        |-> res.source_addr_low == '0 && res.datagram_length == '0 && !res.source_is_ipv6)
        else $error("error result carries header fields");

endmodule

// File: design/uotfp_out_reg.sv
// Result register of the frame parser: holds one result until the consumer takes it,
// and accepts a new one in the same cycle as the old one leaves. Depends on uotfp_pkg.
module uotfp_out_reg
    import uotfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_accept,
    input  result_t res,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign s_ready = !valid_reg || m_ready;
    assign load    = in_accept && res.valid;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

    // A held result is never overwritten while the consumer stalls.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !load)
        else $error("result overwritten while stalled");

    // Only defined kinds are presented.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.kind <= KIND_STREAM_END)
        else $error("undefined result kind presented");

endmodule

// File: design/udp_over_tcp_frame_parser_top.sv
// Top level of the datagram-over-stream frame parser: byte input channel, result
// channel and capacity register port. Depends on uotfp_pkg, uotfp_parser, uotfp_out_reg.
//
//  Channel   Handshake            Payload
//  -------   ------------------   --------------------------------------------------
//  input     s_valid / s_ready    s_stream_byte, s_stream_end
//  result    m_valid / m_ready    m_result_kind, m_payload_byte, m_last_of_datagram,
//                                 m_source_is_ipv6, m_source_addr_high/low,
//                                 m_source_port, m_datagram_length
//  config    cfg_wr_en            cfg_wr_data (buffer capacity, reset 65535)
//
// One stream byte is taken per cycle unless stalled; each byte updates the header
// registers in a single pass and any result it causes appears on m_valid the next cycle.
// Throughput is set by the single result register: s_ready is high whenever that
// register is empty or being emptied in the same cycle, so a stall on the result side
// holds the input only while a result is waiting.
// Reset (aresetn low at a rising edge) returns the parser to waiting for a family
// byte, clears the header registers and sets the capacity to 65535.
module udp_over_tcp_frame_parser_top
    import uotfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Capacity register write port.
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    // Stream byte input.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_stream_byte,
    input  logic              s_stream_end,
    // Result output.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_result_kind,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic              m_last_of_datagram,
    output logic              m_source_is_ipv6,
    output logic [ADDR_W-1:0] m_source_addr_high,
    output logic [ADDR_W-1:0] m_source_addr_low,
    output logic [WORD_W-1:0] m_source_port,
    output logic [WORD_W-1:0] m_datagram_length
);

    logic    in_accept;
    result_t parse_res;
    result_t out_res;

    // A transaction on the input side completes when both valid and ready are high.
    assign in_accept = s_valid && s_ready;

    // The parser keeps the frame state and works out the result of each byte.
    uotfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_byte     (s_stream_byte),
        .in_end      (s_stream_end),
        .res         (parse_res)
    );

    // The result register decouples the consumer's stalls from the byte stream.
    uotfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .res       (parse_res),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (out_res)
    );

    assign m_result_kind      = out_res.kind;
    assign m_payload_byte     = out_res.payload_byte;
    assign m_last_of_datagram = out_res.last_of_datagram;
    assign m_source_is_ipv6   = out_res.source_is_ipv6;
    assign m_source_addr_high = out_res.source_addr_high;
    assign m_source_addr_low  = out_res.source_addr_low;
    assign m_source_port      = out_res.source_port;
    assign m_datagram_length  = out_res.datagram_length;

    // An IPv4 source never carries upper address bits.
    a_v4_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_source_is_ipv6 |-> m_source_addr_high == '0)
        else $error("IPv4 result with upper address bits set");

endmodule

// File: test/tb_uotfp_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the datagram-over-stream frame parser testbench: the result record
// and a class that predicts results from accepted stream bytes and checks them.
// Depends on uotfp_pkg for widths, result kinds, family codes and phase encoding.
package tb_uotfp_pkg;
    import uotfp_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              is_last;
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [WORD_W-1:0] port;
        logic [WORD_W-1:0] length;
    } frame_result_t;

    class deframer_scoreboard;
        logic [WORD_W-1:0] capacity;
        int unsigned       errors;
        phase_t            phase;
        logic [WORD_W-1:0] byte_count;
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [WORD_W-1:0] port;
        logic [WORD_W-1:0] length;
        logic              oversize;
        frame_result_t     awaited_results[$];

        function new();
            capacity   = '1;
            errors     = 0;
            phase      = PH_FAMILY;
            byte_count = '0;
            is_ipv6    = 1'b0;
            addr_high  = '0;
            addr_low   = '0;
            port       = '0;
            length     = '0;
            oversize   = 1'b0;
        endfunction

        function void set_capacity(logic [WORD_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction

        function void restart_frame();
            phase      = PH_FAMILY;
            byte_count = '0;
            oversize   = 1'b0;
        endfunction

        // Only payload bytes and empty datagrams carry the frame header.
        function void push_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                  logic is_last);
            frame_result_t r;
            r = '0;
            r.kind = kind;
            if (kind == KIND_PAYLOAD || kind == KIND_EMPTY) begin
                r.payload_byte = data;
                r.is_last      = is_last;
                r.is_ipv6      = is_ipv6;
                r.addr_high    = addr_high;
                r.addr_low     = addr_low;
                r.port         = port;
                r.length       = length;
            end
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        // Advances the parse state by one accepted stream byte.
        function void note_stream_item(logic [BYTE_W-1:0] data, logic ended);
            logic is_last;
            if (ended) begin
                restart_frame();
                push_result(KIND_STREAM_END, '0, 1'b0);
                return;
            end
            case (phase)
                PH_DOMAIN: begin
                    restart_frame();
                    push_result(KIND_PROTO_ERR, '0, 1'b0);
                end
                PH_ADDR: begin
                    if (is_ipv6) begin
                        addr_high = {addr_high[ADDR_W-9:0], addr_low[ADDR_W-1 -: 8]};
                        addr_low  = {addr_low[ADDR_W-9:0], data};
                    end else begin
                        addr_low = {32'h0, addr_low[23:0], data};
                    end
                    byte_count++;
                    if (byte_count >= (is_ipv6 ? ADDR_BYTES_V6 : ADDR_BYTES_V4)) begin
                        byte_count = '0;
                        phase      = PH_PORT;
                    end
                end
                PH_PORT: begin
                    port = {port[7:0], data};
                    byte_count++;
                    if (byte_count >= FIELD_BYTES) begin
                        byte_count = '0;
                        phase      = PH_LEN;
                    end
                end
                PH_LEN: begin
                    length = {length[7:0], data};
                    byte_count++;
                    if (byte_count >= FIELD_BYTES) begin
                        byte_count = '0;
                        if (length == '0) begin
                            restart_frame();
                            push_result(KIND_EMPTY, '0, 1'b0);
                        end else begin
                            oversize = (length > capacity);
                            phase    = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    byte_count++;
                    is_last = (byte_count >= length);
                    if (oversize) begin
                        if (is_last) begin
                            restart_frame();
                            push_result(KIND_SIZE_ERR, '0, 1'b0);
                        end
                    end else begin
                        push_result(KIND_PAYLOAD, data, is_last);
                        if (is_last)
                            restart_frame();
                    end
                end
                default: begin
                    restart_frame();
                    if (data == FAM_IPV4 || data == FAM_IPV6) begin
                        is_ipv6   = (data == FAM_IPV6);
                        addr_high = '0;
                        addr_low  = '0;
                        port      = '0;
                        length    = '0;
                        phase     = PH_ADDR;
                    end else if (data == FAM_DOMAIN) begin
                        phase = PH_DOMAIN;
                    end else begin
                        push_result(KIND_PROTO_ERR, '0, 1'b0);
                    end
                end
            endcase
        endfunction

        function bit field_differs(string label, logic [ADDR_W-1:0] want,
                                   logic [ADDR_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            bit            bad;
            if (awaited_results.size() == 0) begin
                $error("result of kind %0d arrived with none expected", got.kind);
                errors++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            bad  = 1'b0;
            bad |= field_differs("result_kind", ADDR_W'(want.kind), ADDR_W'(got.kind));
            bad |= field_differs("payload_byte", ADDR_W'(want.payload_byte),
                                 ADDR_W'(got.payload_byte));
            bad |= field_differs("last_of_datagram", ADDR_W'(want.is_last),
                                 ADDR_W'(got.is_last));
            bad |= field_differs("source_is_ipv6", ADDR_W'(want.is_ipv6),
                                 ADDR_W'(got.is_ipv6));
            bad |= field_differs("source_addr_high", want.addr_high, got.addr_high);
            bad |= field_differs("source_addr_low", want.addr_low, got.addr_low);
            bad |= field_differs("source_port", ADDR_W'(want.port), ADDR_W'(got.port));
            bad |= field_differs("datagram_length", ADDR_W'(want.length),
                                 ADDR_W'(got.length));
            if (bad)
                errors++;
        endfunction
    endclass

endpackage

// File: test/tb_udp_over_tcp_frame_parser_top.sv
`timescale 1ns / 100ps
// Testbench top for udp_over_tcp_frame_parser_top: drives stream bytes, capacity writes
// and result back-pressure, and checks every result against the scoreboard's prediction.
// Depends on uotfp_pkg, tb_uotfp_pkg and the parser RTL.
module tb_udp_over_tcp_frame_parser_top;
    import uotfp_pkg::*;
    import tb_uotfp_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off used once
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles without any transaction
    localparam int SETTLE_CYCLES   = 8;     // settle time once all results are taken
    localparam int ITEMS_PER_PHASE = 200;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_MOSTLY
    } rx_pattern_t;

    logic              aclk;
    logic              aresetn            = 1'b0;
    logic              cfg_wr_en          = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data        = '0;
    logic              s_valid            = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_stream_byte      = '0;
    logic              s_stream_end       = 1'b0;
    logic              m_valid;
    logic              m_ready            = 1'b0;
    logic [KIND_W-1:0] m_result_kind;
    logic [BYTE_W-1:0] m_payload_byte;
    logic              m_last_of_datagram;
    logic              m_source_is_ipv6;
    logic [ADDR_W-1:0] m_source_addr_high;
    logic [ADDR_W-1:0] m_source_addr_low;
    logic [WORD_W-1:0] m_source_port;
    logic [WORD_W-1:0] m_datagram_length;

    deframer_scoreboard sb;
    int unsigned        items_sent    = 0;
    int unsigned        burst_left    = 0;
    bit                 steady_sender = 1'b0;
    bit                 hold_req      = 1'b0;

    udp_over_tcp_frame_parser_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_stream_byte      (s_stream_byte),
        .s_stream_end       (s_stream_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_payload_byte     (m_payload_byte),
        .m_last_of_datagram (m_last_of_datagram),
        .m_source_is_ipv6   (m_source_is_ipv6),
        .m_source_addr_high (m_source_addr_high),
        .m_source_addr_low  (m_source_addr_low),
        .m_source_port      (m_source_port),
        .m_datagram_length  (m_datagram_length)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // The sender works in bursts. At the end of each burst it drops valid unless it is
    // in a steady stretch, so gaps land on every parse phase.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender) begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Offers one stream byte and waits for the transaction. Valid is only ever raised
    // here, so a back-to-back item keeps it high without a drop in between.
    task automatic send_item(input logic [BYTE_W-1:0] data, input logic ended);
        s_valid       <= 1'b1;
        s_stream_byte <= data;
        s_stream_end  <= ended;
        do @(posedge aclk); while (!s_ready);
        sb.note_stream_item(data, ended);
        items_sent++;
        pace();
    endtask

    // Sends a whole IPv4 or IPv6 frame with a random payload. A non-negative cut
    // stops after that many bytes, which leaves the frame broken off.
    task automatic send_frame(input bit v6, input logic [127:0] addr,
                              input logic [WORD_W-1:0] port, input logic [WORD_W-1:0] len,
                              input int cut);
        logic [BYTE_W-1:0] frame_bytes[$];
        int                n;
        frame_bytes.insert(frame_bytes.size(), v6 ? FAM_IPV6 : FAM_IPV4);
        for (int i = (v6 ? 15 : 3); i >= 0; i--)
            frame_bytes.insert(frame_bytes.size(), addr[i*8 +: 8]);
        frame_bytes.insert(frame_bytes.size(), port[15:8]);
        frame_bytes.insert(frame_bytes.size(), port[7:0]);
        frame_bytes.insert(frame_bytes.size(), len[15:8]);
        frame_bytes.insert(frame_bytes.size(), len[7:0]);
        for (int i = 0; i < int'(len); i++)
            frame_bytes.insert(frame_bytes.size(), BYTE_W'($urandom));
        n = (cut < 0) ? frame_bytes.size() : cut;
        for (int i = 0; i < n; i++)
            send_item(frame_bytes[i], 1'b0);
    endtask

    // Pauses the sender until every predicted result has been taken, then lets the
    // block settle so that a capacity write finds it idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [WORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Mostly short payloads, with lengths around the capacity when it is small so that
    // both sides of the size limit are hit.
    function automatic logic [WORD_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 75)
            return WORD_W'($urandom_range(1, 12));
        if (r < 90 || sb.capacity >= 64)
            return WORD_W'($urandom_range(13, 64));
        return sb.capacity + WORD_W'($urandom_range(0, 1));
    endfunction

    task automatic random_traffic(input int unsigned target);
        int unsigned       choice;
        int                total;
        bit                v6;
        logic [127:0]      addr;
        logic [WORD_W-1:0] len;
        while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0)
                steady_sender = !steady_sender;
            choice = $urandom_range(0, 99);
            v6     = 1'($urandom_range(0, 1));
            addr   = {$urandom, $urandom, $urandom, $urandom};
            len    = pick_length();
            if (choice < 70) begin
                send_frame(v6, addr, WORD_W'($urandom), len, -1);
            end else if (choice < 76) begin
                send_item(FAM_DOMAIN, 1'b0);
                send_item(BYTE_W'($urandom), 1'b0);
            end else if (choice < 82) begin
                send_item(BYTE_W'($urandom_range(3, 255)), 1'b0);
            end else if (choice < 88) begin
                send_item(BYTE_W'($urandom), 1'b1);
            end else if (choice < 94) begin
                // A frame broken off somewhere inside, then the stream fails.
                total = 5 + (v6 ? 16 : 4) + int'(len);
                send_frame(v6, addr, WORD_W'($urandom), len, $urandom_range(1, total - 1));
                send_item(BYTE_W'($urandom), 1'b1);
            end else begin
                send_item(BYTE_W'($urandom), 1'b0);
                if ($urandom_range(0, 1))
                    send_item(BYTE_W'($urandom), 1'b1);
            end
        end
    endtask

    // Hand-picked frames: unknown families, the domain family, empty and short
    // datagrams with all-zero and all-one headers, and the stream ending in the family,
    // address, payload and domain phases.
    task automatic run_directed();
        send_item(8'hFF, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(FAM_DOMAIN, 1'b0);
        send_item(8'h00, 1'b0);
        send_frame(1'b0, '1, 16'hFFFF, 16'h0000, -1);
        send_frame(1'b0, '0, 16'h0000, 16'h0001, -1);
        send_frame(1'b1, '1, 16'h8001, 16'h0002, -1);
        send_item(8'hFF, 1'b1);
        send_frame(1'b0, {$urandom, $urandom, $urandom, $urandom}, 16'h1234, 16'h0005, 3);
        send_item(8'h00, 1'b1);
        send_frame(1'b1, {$urandom, $urandom, $urandom, $urandom}, 16'h4321, 16'h0004, 24);
        send_item(8'hA5, 1'b1);
        send_item(FAM_DOMAIN, 1'b0);
        send_item(8'h5A, 1'b1);
    endtask

    // Monitor: every result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        frame_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind         = m_result_kind;
            got.payload_byte = m_payload_byte;
            got.is_last      = m_last_of_datagram;
            got.is_ipv6      = m_source_is_ipv6;
            got.addr_high    = m_source_addr_high;
            got.addr_low     = m_source_addr_low;
            got.port         = m_source_port;
            got.length       = m_datagram_length;
            sb.check_result(got);
        end
    end

    // Receiver: picks a new stall pattern whenever the current one runs out. When a
    // hold-off is requested it keeps ready low for a long stretch, so the single result
    // register fills and the block has to stall its input.
    initial begin
        rx_pattern_t pattern;
        int unsigned pattern_left;
        int unsigned tick;
        pattern      = RX_ALWAYS;
        pattern_left = 0;
        tick         = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 150);
                end
                pattern_left--;
                tick++;
                case (pattern)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready <= (tick % 7) > 2;
                    default:     m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transaction happens on either channel for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** udp_over_tcp_frame_parser_top: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Capacity at its reset value of 65535.
        run_directed();
        random_traffic(items_sent + ITEMS_PER_PHASE);

        // Capacity zero: any non-empty payload is too long, an empty one still passes.
        drain();
        write_capacity('0);
        send_frame(1'b0, '1, 16'h0102, 16'h0003, -1);
        send_frame(1'b1, '0, 16'h0000, 16'h0000, -1);
        random_traffic(items_sent + ITEMS_PER_PHASE);

        // Small capacity: a payload of exactly the capacity passes, one more fails.
        drain();
        write_capacity(16'd5);
        send_frame(1'b0, {$urandom, $urandom, $urandom, $urandom}, 16'hBEEF, 16'd5, -1);
        send_frame(1'b1, {$urandom, $urandom, $urandom, $urandom}, 16'hCAFE, 16'd6, -1);
        random_traffic(items_sent + ITEMS_PER_PHASE);

        // Full capacity. The receiver holds off while a long datagram is offered, then
        // a datagram of the largest length is accepted and broken off by the stream end.
        drain();
        write_capacity('1);
        hold_req = 1'b1;
        send_frame(1'b1, {$urandom, $urandom, $urandom, $urandom}, 16'h0050, 16'd48, -1);
        send_frame(1'b0, {$urandom, $urandom, $urandom, $urandom}, 16'hFFFF, 16'hFFFF, 60);
        send_item(8'h00, 1'b1);
        random_traffic(items_sent + ITEMS_PER_PHASE);

        drain();
        write_capacity(WORD_W'($urandom_range(2, 40)));
        random_traffic(items_sent + ITEMS_PER_PHASE);

        drain();
        write_capacity(16'd1);
        random_traffic(items_sent + ITEMS_PER_PHASE);

        drain();
        if (sb.outstanding() != 0)
            $error("%0d expected results never arrived", sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("** udp_over_tcp_frame_parser_top: PASSED **");
        end else begin
            $display("** udp_over_tcp_frame_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
